/* rtl/twbft_pkg.sv */
// shared types, constants and codes of the two-wire bus frame transceiver
package twbft_pkg;

  // frame geometry
  localparam int FRAME_BITS = 32;
  localparam int WORD_W     = 32;
  localparam int SHIFT_W    = (FRAME_BITS > WORD_W) ? FRAME_BITS : WORD_W;
  localparam int IDX_W      = $clog2(SHIFT_W);
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);
  localparam int TICK_W     = 4;
  localparam int LEFT_W     = 6;
  localparam int CMD_W      = 2;
  localparam int STATE_W    = 2;

  localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(4);

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_SEND = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // bus phase
  typedef enum logic [STATE_W-1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_SEND = 2'd2,
    PH_TERM = 2'd3
  } phase_t;

  // one input item
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              carrier_level;
    logic              rx_level;
    logic [WORD_W-1:0] send_word;
  } item_t;

  // one result item
  typedef struct packed {
    logic               tx_level;
    logic               load_enable;
    logic               frame_valid;
    logic [WORD_W-1:0]  frame_word;
    logic               abort_flag;
    logic [LEFT_W-1:0]  abort_bits_left;
    logic               send_rejected;
    logic               frame_complete;
    logic [STATE_W-1:0] bus_state;
  } result_t;

endpackage

/* rtl/twbft_if.sv */
// handshake channels of the transceiver: input items, result items, configuration
interface twbft_in_if;
  import twbft_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              carrier_level;
  logic              rx_level;
  logic [WORD_W-1:0] send_word;
  modport source (output valid, command, carrier_level, rx_level, send_word, input ready);
  modport sink   (input valid, command, carrier_level, rx_level, send_word, output ready);
endinterface

interface twbft_out_if;
  import twbft_pkg::*;
  logic               valid;
  logic               ready;
  logic               tx_level;
  logic               load_enable;
  logic               frame_valid;
  logic [WORD_W-1:0]  frame_word;
  logic               abort_flag;
  logic [LEFT_W-1:0]  abort_bits_left;
  logic               send_rejected;
  logic               frame_complete;
  logic [STATE_W-1:0] bus_state;
  modport source (output valid, tx_level, load_enable, frame_valid, frame_word, abort_flag,
                  abort_bits_left, send_rejected, frame_complete, bus_state, input ready);
  modport sink   (input valid, tx_level, load_enable, frame_valid, frame_word, abort_flag,
                  abort_bits_left, send_rejected, frame_complete, bus_state, output ready);
endinterface

interface twbft_cfg_if;
  import twbft_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] bit_ticks;
  modport source (output valid, bit_ticks, input ready);
  modport sink   (input valid, bit_ticks, output ready);
endinterface

/* rtl/two_wire_bus_frame_transceiver_unit.sv */
// top level: input register, bus state update, result register, configuration
// an accepted item is held in the input register, and its result is registered in the result register, which offers it
// throughput: one item per cycle while results are taken
// the result register frees the input side when the sink takes a result
// reset: synchronous; idle phase, tx high, load off, 4 ticks per bit,
// no item held in either register
module two_wire_bus_frame_transceiver_unit
  import twbft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  twbft_in_if.sink    item_in,
  twbft_out_if.source result_out,
  twbft_cfg_if.sink   cfg
);

  logic              s1_valid;
  item_t             s1_item;
  logic              out_valid;
  result_t           out_data;
  logic              step;
  result_t           result;
  logic [TICK_W-1:0] bit_ticks;

  assign step          = s1_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !s1_valid || step;
  assign cfg.ready     = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= TICKS_RESET;
    end else if (cfg.valid) begin
      bit_ticks <= cfg.bit_ticks;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      s1_item.command       <= item_in.command;
      s1_item.carrier_level <= item_in.carrier_level;
      s1_item.rx_level      <= item_in.rx_level;
      s1_item.send_word     <= item_in.send_word;
    end
  end

  twbft_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (s1_item),
    .bit_ticks (bit_ticks),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.tx_level        = out_data.tx_level;
  assign result_out.load_enable     = out_data.load_enable;
  assign result_out.frame_valid     = out_data.frame_valid;
  assign result_out.frame_word      = out_data.frame_word;
  assign result_out.abort_flag      = out_data.abort_flag;
  assign result_out.abort_bits_left = out_data.abort_bits_left;
  assign result_out.send_rejected   = out_data.send_rejected;
  assign result_out.frame_complete  = out_data.frame_complete;
  assign result_out.bus_state       = out_data.bus_state;

endmodule

/* rtl/twbft_core.sv */
// bus state registers and the single-pass update for one item
module twbft_core
  import twbft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  item_t             item,
  input  logic [TICK_W-1:0] bit_ticks,
  output result_t           result
);

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   ticks_remaining, ticks_remaining_next;
  logic [BITS_W-1:0]   bits_remaining, bits_remaining_next;
  logic [SHIFT_W-1:0]  frame_shift, frame_shift_next;
  logic                tx_drive, tx_drive_next;
  logic                load_drive, load_drive_next;

  logic [TICK_W-1:0]   ticks_dec;
  logic [BITS_W-1:0]   bits_dec;
  logic [SHIFT_W-1:0]  send_ext;
  logic                valid, aborted, rejected, complete;
  logic [LEFT_W-1:0]   abort_left;

  assign ticks_dec = ticks_remaining - TICK_W'(1);
  assign bits_dec  = bits_remaining - BITS_W'(1);
  assign send_ext  = SHIFT_W'(item.send_word);

  // next state and flags for the current item
  always_comb begin
    phase_next           = phase;
    ticks_remaining_next = ticks_remaining;
    bits_remaining_next  = bits_remaining;
    frame_shift_next     = frame_shift;
    tx_drive_next        = tx_drive;
    load_drive_next      = load_drive;
    valid                = 1'b0;
    aborted              = 1'b0;
    rejected             = 1'b0;
    complete             = 1'b0;
    abort_left           = '0;
    unique case (cmd_t'(item.command))
      CMD_EDGE: begin
        if (phase == PH_IDLE) begin
          phase_next           = PH_RECV;
          ticks_remaining_next = bit_ticks >> 1;
          bits_remaining_next  = BITS_W'(FRAME_BITS);
          frame_shift_next     = '0;
        end
      end
      CMD_SEND: begin
        if (phase != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          phase_next           = PH_SEND;
          frame_shift_next     = send_ext;
          ticks_remaining_next = bit_ticks;
          bits_remaining_next  = BITS_W'(FRAME_BITS - 1);
          load_drive_next      = 1'b1;
          tx_drive_next        = send_ext[FRAME_BITS-1];
        end
      end
      CMD_TICK: begin
        if (phase != PH_IDLE) begin
          ticks_remaining_next = ticks_dec;
          if (ticks_dec == '0) begin
            unique case (phase)
              // sample one bit or abort on lost carrier
              PH_RECV: begin
                if (!item.carrier_level) begin
                  phase_next = PH_IDLE;
                  aborted    = 1'b1;
                  abort_left = LEFT_W'(bits_remaining);
                end else begin
                  frame_shift_next     = {frame_shift[SHIFT_W-2:0], item.rx_level};
                  bits_remaining_next  = bits_dec;
                  ticks_remaining_next = bit_ticks;
                  if (bits_dec == '0) begin
                    valid      = 1'b1;
                    phase_next = PH_TERM;
                  end
                end
              end
              // drive next bit or release the line
              PH_SEND: begin
                ticks_remaining_next = bit_ticks;
                if (bits_remaining != '0) begin
                  bits_remaining_next = bits_dec;
                  tx_drive_next       = frame_shift[IDX_W'(bits_dec)];
                end else begin
                  tx_drive_next   = 1'b1;
                  load_drive_next = 1'b0;
                  phase_next      = PH_TERM;
                end
              end
              // wait for carrier off
              PH_TERM: begin
                if (item.carrier_level) begin
                  ticks_remaining_next = TICK_W'(1);
                end else begin
                  phase_next = PH_IDLE;
                  complete   = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    result.tx_level        = tx_drive_next;
    result.load_enable     = load_drive_next;
    result.frame_valid     = valid;
    result.frame_word      = valid ? frame_shift_next[WORD_W-1:0] : '0;
    result.abort_flag      = aborted;
    result.abort_bits_left = abort_left;
    result.send_rejected   = rejected;
    result.frame_complete  = complete;
    result.bus_state       = phase_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      ticks_remaining <= '0;
      bits_remaining  <= '0;
      frame_shift     <= '0;
      tx_drive        <= 1'b1;
      load_drive      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      ticks_remaining <= ticks_remaining_next;
      bits_remaining  <= bits_remaining_next;
      frame_shift     <= frame_shift_next;
      tx_drive        <= tx_drive_next;
      load_drive      <= load_drive_next;
    end
  end

endmodule

/* rtl/twbft_checker.sv */
// port-level checks of the transceiver and their binding to the top level
module twbft_port_checks
  import twbft_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               tx_level,
  input logic               load_enable,
  input logic               frame_valid,
  input logic               abort_flag,
  input logic [LEFT_W-1:0]  abort_bits_left,
  input logic [STATE_W-1:0] bus_state
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // a full frame leaves the bus terminating
  a_frame_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_valid |-> bus_state == STATE_W'(PH_TERM) && !abort_flag)
    else $error("frame received without terminating phase");

  // an abort returns to idle with bits still expected
  a_abort_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && abort_flag |-> bus_state == STATE_W'(PH_IDLE) && abort_bits_left != '0)
    else $error("abort with bad phase or bit count");

  // load is on only while sending, and tx is high whenever load is off
  a_load_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (load_enable == (bus_state == STATE_W'(PH_SEND))) && (load_enable || tx_level))
    else $error("load or tx level out of step with phase");

endmodule

bind two_wire_bus_frame_transceiver_unit twbft_port_checks u_twbft_port_checks (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .tx_level        (result_out.tx_level),
  .load_enable     (result_out.load_enable),
  .frame_valid     (result_out.frame_valid),
  .abort_flag      (result_out.abort_flag),
  .abort_bits_left (result_out.abort_bits_left),
  .bus_state       (result_out.bus_state)
);
